### rtl/tlg_pkg.sv
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared types, constants and elaboration-time tables for the tremolo block.
// ----------------------------------------------------------------------------
package tlg_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int SAMPLE_RATE    = 44100;
    localparam int COS_TABLE_BITS = 10;
    localparam int QTR_BITS       = COS_TABLE_BITS - 2;
    localparam int QTR            = 1 << QTR_BITS;
    localparam int MAG_W          = 16;
    localparam int DEPTH_W        = 7;
    localparam int DEPTH_Q_W      = 17;
    localparam int RATE_W         = 5;
    localparam int RATE_N         = 1 << RATE_W;

    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 7;

    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_ON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE      = 2'd2;

    // shared serial multiplier: multiplicand width, multiplier bits
    localparam int MUL_W  = 31;
    localparam int MUL_N  = 17;
    localparam int PROD_W = MUL_W + MUL_N;

    localparam longint ONE_Q30 = 64'sd1 << 30;

    localparam longint POLY [8] = '{
        64'sd1073741824, -64'sd1324675879, 64'sd272375560, -64'sd22401992,
        64'sd987048, -64'sd27060, 64'sd506, -64'sd7
    };

    typedef logic [MAG_W-1:0]     cos_tab_t   [QTR];
    typedef logic [DEPTH_Q_W-1:0] depth_tab_t [1 << DEPTH_W];

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] mcand;
        logic [MUL_N-1:0] mplier;
    } mul_req_t;

    // quarter-wave cosine magnitude, Q1.15, round half up, 0..32768
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t t;
        longint   u;
        longint   v;
        longint   acc;
        longint   m;
        for (int j = 0; j < QTR; j++)
        begin
            u   = longint'(j) <<< (30 - QTR_BITS);
            v   = (u * u) / ONE_Q30;
            acc = POLY[7];
            for (int i = 6; i >= 0; i--)
            begin
                acc = POLY[i] + (acc * v) / ONE_Q30;
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            m    = (acc * 32768 + (64'sd1 <<< 29)) / ONE_Q30;
            t[j] = MAG_W'(m);
        end
        return t;
    endfunction

    // depth in percent to Q1.15 fraction, clamped at 100
    function automatic depth_tab_t build_depth_tab();
        depth_tab_t t;
        longint     p;
        for (int k = 0; k < (1 << DEPTH_W); k++)
        begin
            p    = (k > 100) ? 64'sd100 : longint'(k);
            t[k] = DEPTH_Q_W'((p * 32768) / 100);
        end
        return t;
    endfunction

    localparam cos_tab_t   COS_MAG = build_cos_tab();
    localparam depth_tab_t DEPTH_Q = build_depth_tab();

endpackage

### rtl/tlg_if.sv
// ----------------------------------------------------------------------------
// tlg_if
// Valid/ready channels: input samples, output samples, register writes.
// ----------------------------------------------------------------------------
interface tlg_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [tlg_pkg::SAMPLE_W-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

interface tlg_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [tlg_pkg::SAMPLE_W-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink   (input valid, input out_sample, output ready);
endinterface

interface tlg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tlg_pkg::CFG_IDX_W-1:0]     index;
    logic [tlg_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/tlg_serial_mul.sv
// ----------------------------------------------------------------------------
// tlg_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module tlg_serial_mul
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tlg_pkg::mul_req_t            req,
    output logic                         busy,
    output logic [tlg_pkg::PROD_W-1:0]   prod
);

    localparam int W     = tlg_pkg::MUL_W;
    localparam int N     = tlg_pkg::MUL_N;
    localparam int CNT_W = $clog2(N + 1);

    logic [W-1:0]     hi_reg;
    logic [W-1:0]     hi_next;
    logic [N-1:0]     lo_reg;
    logic [N-1:0]     lo_next;
    logic [W-1:0]     mcand_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic [W:0]       sum;

    always_comb
    begin
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (req.start)
        begin
            hi_next   = '0;
            lo_next   = req.mplier;
            cnt_next  = CNT_W'(N);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = sum[W:1];
            lo_next  = {sum[0], lo_reg[N-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        if (req.start)
        begin
            mcand_reg <= req.mcand;
        end
    end

    assign busy = busy_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

### rtl/tlg_phase_acc.sv
// ----------------------------------------------------------------------------
// tlg_phase_acc
// LFO phase register with a bit-serial adder; the phase rotates once per step.
// ----------------------------------------------------------------------------
module tlg_phase_acc
#(
    parameter int PHASE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PHASE_BITS-1:0] inc,
    output logic                  busy,
    output logic [PHASE_BITS-1:0] phase
);

    localparam int CNT_W = $clog2(PHASE_BITS + 1);

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [PHASE_BITS-1:0] inc_reg;
    logic [PHASE_BITS-1:0] inc_next;
    logic                  carry_reg;
    logic                  carry_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  sum_bit;

    always_comb
    begin
        sum_bit    = phase_reg[0] ^ inc_reg[0] ^ carry_reg;
        phase_next = phase_reg;
        inc_next   = inc_reg;
        carry_next = carry_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (start)
        begin
            inc_next   = inc;
            carry_next = 1'b0;
            cnt_next   = CNT_W'(PHASE_BITS);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            phase_next = {sum_bit, phase_reg[PHASE_BITS-1:1]};
            inc_next   = {1'b0, inc_reg[PHASE_BITS-1:1]};
            carry_next = (phase_reg[0] & inc_reg[0]) | (carry_reg & (phase_reg[0] ^ inc_reg[0]));
            cnt_next   = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            carry_reg <= 1'b0;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inc_reg <= inc_next;
    end

    assign busy  = busy_reg;
    assign phase = phase_reg;

endmodule

### rtl/tremolo_lfo_gain_top.sv
// With the effect on, an input sample passes the cosine lookup, the first serial
// multiply, the gain step, the second serial multiply and the saturate step; the
// phase update overlaps them, and the output register loads only once it is done. In
// pass-through the sample goes straight to the output register. One item in flight:
// the next sample is taken once the current one has moved to the output register.
// Reset (async, active low): phase 0, effect off, depth 10 %, rate 1 Hz.
// ----------------------------------------------------------------------------
// tremolo_lfo_gain_top
// Cosine-LFO tremolo: sample times (1-d) + d*cos(phase), saturated to int16.
// ----------------------------------------------------------------------------
module tremolo_lfo_gain_top
#(
    parameter int PHASE_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    tlg_in_if.sink    samples,
    tlg_out_if.source results,
    tlg_cfg_if.sink   cfg
);

    localparam int SW  = tlg_pkg::SAMPLE_W;
    localparam int CTB = tlg_pkg::COS_TABLE_BITS;
    localparam int QB  = tlg_pkg::QTR_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOK = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_GAIN = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_SAT  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [PHASE_BITS-1:0] inc_tab [tlg_pkg::RATE_N];

    for (genvar g = 0; g < tlg_pkg::RATE_N; g++)
    begin : g_inc
        localparam longint INC_FULL = (64'(g) <<< PHASE_BITS) / tlg_pkg::SAMPLE_RATE;
        assign inc_tab[g] = PHASE_BITS'(INC_FULL);
    end

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic                           effect_on_reg;
    logic [tlg_pkg::DEPTH_W-1:0]    depth_reg;
    logic [tlg_pkg::RATE_W-1:0]     rate_reg;
    logic [SW-1:0]                  sample_reg;
    logic [CTB-1:0]                 idx_reg;
    logic                           neg_reg;
    logic                           neg_next;
    logic [SW-1:0]                  res_reg;
    logic [SW-1:0]                  res_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [SW-1:0]                  out_sample_reg;

    logic                           in_xfer;
    logic                           cfg_xfer;
    logic                           out_load;
    tlg_pkg::mul_req_t              mreq;
    logic                           mul_busy;
    logic [tlg_pkg::PROD_W-1:0]     prod;
    logic                           ph_start;
    logic                           ph_busy;
    logic [PHASE_BITS-1:0]          phase;

    logic [1:0]                     quad;
    logic [QB-1:0]                  r;
    logic [tlg_pkg::MAG_W-1:0]      mag;
    logic [tlg_pkg::MAG_W-1:0]      mag_pos;
    logic [16:0]                    m_one;
    logic signed [34:0]             g_wide;
    logic [34:0]                    g_abs;
    logic [SW-1:0]                  s_mag;
    logic [17:0]                    y_mag;

    assign samples.ready = (state_reg == ST_IDLE);
    assign in_xfer       = samples.valid && samples.ready;
    assign cfg.ready     = 1'b1;
    assign cfg_xfer      = cfg.valid && cfg.ready;
    assign ph_start      = in_xfer && effect_on_reg;

    // cosine from quarter table
    always_comb
    begin
        quad    = idx_reg[CTB-1 -: 2];
        r       = idx_reg[QB-1:0];
        if (quad[0])
        begin
            mag = (r == '0) ? '0 : tlg_pkg::COS_MAG[QB'(0) - r];
        end
        else
        begin
            mag = tlg_pkg::COS_MAG[r];
        end
        mag_pos = (mag > 16'd32767) ? 16'd32767 : mag;
        // 32768 - c
        if (quad[0] ^ quad[1])
        begin
            m_one = 17'd32768 + {1'b0, mag};
        end
        else
        begin
            m_one = 17'd32768 - {1'b0, mag_pos};
        end
    end

    always_comb
    begin
        g_wide = 35'sh4000_0000 - $signed({1'b0, prod[33:0]});
        g_abs  = g_wide[34] ? 35'(-g_wide) : 35'(g_wide);
        s_mag  = sample_reg[SW-1] ? SW'(-sample_reg) : sample_reg;
        y_mag  = prod[tlg_pkg::PROD_W-1 -: 18];
    end

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        out_load       = 1'b0;
        mreq.start     = 1'b0;
        mreq.mcand     = '0;
        mreq.mplier    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    res_next   = samples.in_sample;
                    state_next = effect_on_reg ? ST_LOOK : ST_DONE;
                end
            end
            ST_LOOK:
            begin
                mreq.start  = 1'b1;
                mreq.mcand  = tlg_pkg::MUL_W'(m_one);
                mreq.mplier = tlg_pkg::DEPTH_Q[depth_reg];
                state_next  = ST_MUL1;
            end
            ST_MUL1:
            begin
                if (!mul_busy)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                mreq.start  = 1'b1;
                mreq.mcand  = g_abs[tlg_pkg::MUL_W-1:0];
                mreq.mplier = tlg_pkg::MUL_N'(s_mag);
                neg_next    = sample_reg[SW-1] ^ g_wide[34];
                state_next  = ST_MUL2;
            end
            ST_MUL2:
            begin
                if (!mul_busy)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                if (neg_reg)
                begin
                    res_next = (y_mag > 18'd32768) ? 16'h8000 : SW'(-y_mag[SW-1:0]);
                end
                else
                begin
                    res_next = (y_mag > 18'd32767) ? 16'h7FFF : y_mag[SW-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ph_busy && (!out_valid_reg || results.ready))
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            effect_on_reg <= 1'b0;
            depth_reg     <= 7'd10;
            rate_reg      <= 5'd1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_xfer)
            begin
                case (cfg.index)
                    tlg_pkg::REG_EFFECT_ON: effect_on_reg <= cfg.data[0];
                    tlg_pkg::REG_DEPTH:     depth_reg     <= cfg.data;
                    tlg_pkg::REG_RATE:      rate_reg      <= cfg.data[tlg_pkg::RATE_W-1:0];
                    default:                effect_on_reg <= effect_on_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        res_reg <= res_next;
        if (in_xfer)
        begin
            sample_reg <= samples.in_sample;
            idx_reg    <= phase[PHASE_BITS-1 -: CTB];
        end
        if (out_load)
        begin
            out_sample_reg <= res_reg;
        end
    end

    tlg_serial_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .busy  (mul_busy),
        .prod  (prod)
    );

    tlg_phase_acc
    #(
        .PHASE_BITS (PHASE_BITS)
    )
    u_phase
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ph_start),
        .inc   (inc_tab[rate_reg]),
        .busy  (ph_busy),
        .phase (phase)
    );

    assign results.valid      = out_valid_reg;
    assign results.out_sample = out_sample_reg;

endmodule

### tb/sv/tremolo_gain_checker.sv
// ----------------------------------------------------------------------------
// tremolo_gain_checker
// Watches the sample, result and register channels of the tremolo block. It
// keeps its own copy of the registers, the LFO phase and the cosine table,
// predicts each output sample and compares it with the next result transfer.
// ----------------------------------------------------------------------------
module tremolo_gain_checker
    import tlg_pkg::*;
#(
    parameter int PHASE_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    tlg_in_if                         samples,
    tlg_out_if                        results,
    tlg_cfg_if                        cfg,
    output int                        mismatch_count,
    output int                        pending,
    output logic [COS_TABLE_BITS-1:0] phase_idx
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ROM_N = 1 << COS_TABLE_BITS;
    localparam int     QB    = COS_TABLE_BITS - 2;
    localparam longint UNITY = 64'sd1 << 30;
    localparam longint COEF [8] = '{
        64'sd1073741824, -64'sd1324675879, 64'sd272375560, -64'sd22401992,
        64'sd987048, -64'sd27060, 64'sd506, -64'sd7
    };

    logic signed [SAMPLE_W-1:0]   cos_rom [ROM_N];
    logic signed [SAMPLE_W-1:0]   expected_samples [$];
    logic signed [SAMPLE_W-1:0]   want;
    logic [PHASE_BITS-1:0]        lfo_phase;
    logic                         effect_on;
    logic [DEPTH_W-1:0]           depth_pct;
    logic [RATE_W-1:0]            rate;

    // Q1.15 cosine for table slot k, even polynomial per quarter wave
    function automatic logic signed [SAMPLE_W-1:0] cos_entry(input int unsigned k);
        int unsigned quad;
        int unsigned r;
        longint      u;
        longint      v;
        longint      acc;
        longint      m;
        quad = (k >> QB) & 3;
        r    = k & ((1 << QB) - 1);
        u    = longint'(r) <<< (30 - QB);
        if (quad == 1 || quad == 3)
        begin
            u = UNITY - u;
        end
        v   = (u * u) / UNITY;
        acc = COEF[7];
        for (int i = 6; i >= 0; i--)
        begin
            acc = COEF[i] + (acc * v) / UNITY;
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        m = (acc * 32768 + (64'sd1 <<< 29)) / UNITY;
        if (quad == 1 || quad == 2)
        begin
            return SAMPLE_W'(-m);
        end
        if (m > 32767)
        begin
            m = 32767;
        end
        return SAMPLE_W'(m);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] modulate_sample(
        input logic signed [SAMPLE_W-1:0] s,
        input logic [DEPTH_W-1:0]         pct,
        input logic signed [SAMPLE_W-1:0] c
    );
        longint dq;
        longint g;
        longint y;
        dq = ((pct > 100) ? 64'sd100 : longint'(pct)) * 32768 / 100;
        g  = (32768 - dq) * 32768 + dq * longint'(c);
        y  = (longint'(s) * g) / UNITY;
        if (y > 32767)
        begin
            y = 32767;
        end
        if (y < -32768)
        begin
            y = -32768;
        end
        return SAMPLE_W'(y);
    endfunction

    function automatic logic [PHASE_BITS-1:0] phase_step(input logic [RATE_W-1:0] hz);
        longint unsigned inc;
        inc = 64'(hz);
        inc = (inc << PHASE_BITS) / 64'(SAMPLE_RATE);
        return PHASE_BITS'(inc);
    endfunction

    initial
    begin
        for (int k = 0; k < ROM_N; k++)
        begin
            cos_rom[k] = cos_entry(k);
        end
    end

    assign phase_idx = lfo_phase[PHASE_BITS-1 -: COS_TABLE_BITS];

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_samples.delete();
            lfo_phase      = '0;
            effect_on      = 1'b0;
            depth_pct      = DEPTH_W'(10);
            rate           = RATE_W'(1);
            mismatch_count = 0;
            pending        = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_EFFECT_ON: effect_on = cfg.data[0];
                    REG_DEPTH:     depth_pct = cfg.data[DEPTH_W-1:0];
                    REG_RATE:      rate      = cfg.data[RATE_W-1:0];
                    default:       ;
                endcase
            end
            if (results.valid && results.ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("out_sample: expected none, actual %0d", results.out_sample);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (results.out_sample !== want)
                    begin
                        $error("out_sample: expected %0d, actual %0d",
                               want, results.out_sample);
                        mismatch_count++;
                    end
                end
            end
            if (samples.valid && samples.ready)
            begin
                if (effect_on)
                begin
                    expected_samples.push_back(
                        modulate_sample(samples.in_sample, depth_pct, cos_rom[phase_idx]));
                    lfo_phase = lfo_phase + phase_step(rate);
                end
                else
                begin
                    expected_samples.push_back(samples.in_sample);
                end
            end
            pending = expected_samples.size();
        end
    end

endmodule

### tb/sv/tremolo_lfo_gain_top_test.sv
// ----------------------------------------------------------------------------
// tremolo_lfo_gain_top_test
// Drives samples and register writes into the tremolo block with random
// gaps and output stalls: a short directed run over the sample extremes and
// register corners, a sweep at full depth through the half-cycle point, then
// random phases with random register settings. The checker judges results.
// ----------------------------------------------------------------------------
module tremolo_lfo_gain_top_test;
    import tlg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_BITS     = 32;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_PHASES  = 3;
    localparam int PHASE_ITEMS    = 180;
    localparam int SWEEP_MAX      = 1500;
    localparam int HALF_CYCLE_IDX = 1 << (COS_TABLE_BITS - 1);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                      clk;
    logic                      rst_n;
    logic                      calm;
    int                        mismatch_count;
    int                        pending;
    int                        cycle_count;
    logic [COS_TABLE_BITS-1:0] phase_idx;

    tlg_in_if  samples_ch ();
    tlg_out_if results_ch ();
    tlg_cfg_if cfg_ch ();

    tremolo_lfo_gain_top #(.PHASE_BITS(PHASE_BITS)) u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    tremolo_gain_checker #(.PHASE_BITS(PHASE_BITS)) u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (samples_ch),
        .results        (results_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .phase_idx      (phase_idx)
    );

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 40);
    endfunction

    // the half-cycle slot is where full depth gives a gain of -1
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (phase_idx == HALF_CYCLE_IDX)
        begin
            return 16'sh8000;
        end
        case (sel)
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = pick_gap();
        if ($urandom_range(0, 49) == 0)
        begin
            calm = !calm;
        end
        if (gap > 0)
        begin
            samples_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_ch.valid     = 1'b1;
        samples_ch.in_sample = s;
        do @(posedge clk); while (!samples_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        samples_ch.valid = 1'b0;
        cfg_ch.valid     = 1'b1;
        cfg_ch.index     = idx;
        cfg_ch.data      = value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        samples_ch.valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_regs(input logic on, input logic [CFG_DATA_W-1:0] pct,
                            input logic [CFG_DATA_W-1:0] hz);
        wait_drained();
        write_reg(REG_EFFECT_ON, CFG_DATA_W'(on));
        write_reg(REG_DEPTH, pct);
        write_reg(REG_RATE, hz);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        results_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                results_ch.ready = 1'b0;
            end
            else
            begin
                results_ch.ready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial
    begin
        int n;
        logic hit;
        logic [CFG_DATA_W-1:0] pct;
        logic [CFG_DATA_W-1:0] hz;

        cycle_count          = 0;
        calm                 = 1'b0;
        rst_n                = 1'b0;
        samples_ch.valid     = 1'b0;
        samples_ch.in_sample = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_EFFECT_ON;
        cfg_ch.data          = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // pass-through at reset settings
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(16'sh0000);
        push_sample(-16'sd1);
        push_sample(16'sd1);

        // full depth, frozen phase: gain just below one
        set_regs(1'b1, 7'd100, 7'd0);
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(-16'sd1);
        push_sample(16'sd1);

        // zero depth: exact unity gain
        set_regs(1'b1, 7'd0, 7'd0);
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(16'sd12345);

        // depth above 100, rate above 20 (upper data bits dropped), unused index
        set_regs(1'b1, 7'd127, 7'h7F);
        write_reg(REG_UNUSED, 7'h55);
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(-16'sd21846);
        push_sample(16'sd1);
        push_sample(16'sh5555);
        push_sample(-16'sh5556);

        // full depth at the fastest rate until the half-cycle slot is hit
        set_regs(1'b1, 7'd100, 7'd31);
        n   = 0;
        hit = 1'b0;
        while (!hit && n < SWEEP_MAX)
        begin
            hit = (phase_idx == HALF_CYCLE_IDX);
            push_sample(pick_sample());
            n++;
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(0, 4))
                0:       pct = 7'd0;
                1:       pct = 7'd100;
                2:       pct = 7'd127;
                default: pct = CFG_DATA_W'($urandom_range(0, 127));
            endcase
            case ($urandom_range(0, 4))
                0:       hz = 7'd0;
                1:       hz = 7'd20;
                2:       hz = 7'd31;
                default: hz = CFG_DATA_W'($urandom_range(0, 127));
            endcase
            calm = ($urandom_range(0, 3) == 0);
            set_regs(($urandom_range(0, 3) != 0), pct, hz);
            repeat (PHASE_ITEMS) push_sample(pick_sample());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
